// ===== src/cpg_pkg.sv =====
package cpg_pkg;

  localparam int CORDIC_STAGES   = 24;
  localparam int GAMMA_FRAC_BITS = 24;
  localparam int SHW             = $clog2(CORDIC_STAGES);
  localparam int XW              = 34;
  localparam int ZW              = 64;
  localparam int OUT_W           = 48;

  localparam logic signed [XW-1:0] CORDIC_X0  = 34'sd652032874;
  localparam logic [63:0]          INV_TWO_PI = 64'h28BE60DB9391054A;
  localparam logic [63:0]          TWO_PI_Q60 = 64'h6487ED5110B4611A;

  typedef enum logic [2:0] {
    REG_RADIUS,
    REG_CENTER_X,
    REG_CENTER_Y,
    REG_CENTER_Z,
    REG_AXIS_U,
    REG_AXIS_V
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]           quad;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cord_t;

  // restoring divide, elaboration only
  function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // arctan(2^-i) as a fraction of a turn, Q.64
  function automatic logic [63:0] atan_f(input int i);
    logic [63:0] acc;
    logic [63:0] t;
    acc = '0;
    if (i == 0) begin
      acc = 64'h2000000000000000;
    end else begin
      for (int k = 0; i * (2 * k + 1) < 64; k++) begin
        t = udiv(INV_TWO_PI >> (i * (2 * k + 1)), 64'(2 * k + 1));
        if (k % 2 == 1) acc = acc - t;
        else            acc = acc + t;
      end
    end
    return acc;
  endfunction

  // 4*pi^2 in Q.56
  function automatic logic [63:0] four_pi_sq_f();
    logic [127:0] pr;
    pr = 128'(TWO_PI_Q60) * 128'(TWO_PI_Q60);
    pr = pr + (128'(1) << 63);
    return pr[127:64];
  endfunction

  localparam logic [63:0] FOUR_PI_SQ = four_pi_sq_f();

endpackage

// ===== src/cpg_in_if.sv =====
interface cpg_in_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] gamma;

  modport source (output valid, output gamma, input ready);
  modport sink   (input valid, input gamma, output ready);
endinterface

// ===== src/cpg_out_if.sv =====
interface cpg_out_if;
  logic valid;
  logic ready;
  logic signed [cpg_pkg::OUT_W-1:0] pos_x;
  logic signed [cpg_pkg::OUT_W-1:0] pos_y;
  logic signed [cpg_pkg::OUT_W-1:0] pos_z;
  logic signed [cpg_pkg::OUT_W-1:0] vel_x;
  logic signed [cpg_pkg::OUT_W-1:0] vel_y;
  logic signed [cpg_pkg::OUT_W-1:0] vel_z;
  logic signed [cpg_pkg::OUT_W-1:0] acc_x;
  logic signed [cpg_pkg::OUT_W-1:0] acc_y;
  logic signed [cpg_pkg::OUT_W-1:0] acc_z;
  logic saturated;

  modport source (output valid, output pos_x, output pos_y, output pos_z,
                  output vel_x, output vel_y, output vel_z,
                  output acc_x, output acc_y, output acc_z,
                  output saturated, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                  input vel_x, input vel_y, input vel_z,
                  input acc_x, input acc_y, input acc_z,
                  input saturated, output ready);
endinterface

// ===== src/cpg_cell.sv =====
module cpg_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [cpg_pkg::SHW-1:0]  shift_i,
  input  logic [63:0]              atan_i,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  cpg_pkg::cord_t           data_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output cpg_pkg::cord_t           data_o
);

  logic           valid_q;
  logic           en;
  cpg_pkg::cord_t data_d, data_q;
  logic signed [cpg_pkg::XW-1:0] dx, dy;

  assign en      = !valid_q || ready_i;
  assign ready_o = en;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    dx          = $signed(data_i.y) >>> shift_i;
    dy          = $signed(data_i.x) >>> shift_i;
    data_d.quad = data_i.quad;
    if (!data_i.z[cpg_pkg::ZW-1]) begin
      data_d.x = data_i.x - dx;
      data_d.y = data_i.y + dy;
      data_d.z = data_i.z - $signed(atan_i);
    end else begin
      data_d.x = data_i.x + dx;
      data_d.y = data_i.y - dy;
      data_d.z = data_i.z + $signed(atan_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      data_q <= data_d;
    end
  end

endmodule

// ===== src/cpg_map.sv =====
module cpg_map (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  cpg_pkg::cord_t     data_i,
  input  logic [31:0]        radius_i,
  input  logic signed [47:0] center_x_i,
  input  logic signed [47:0] center_y_i,
  input  logic signed [47:0] center_z_i,
  input  logic [59:0]        axis_u_i,
  input  logic [59:0]        axis_v_i,
  cpg_out_if.source          out_if
);

  localparam int XW  = cpg_pkg::XW;
  localparam int PW  = XW + 33;
  localparam int PAW = PW - 22;
  localparam int VW  = 50;
  localparam int MW  = 70;
  localparam int RW  = MW - 18;
  localparam int SW  = RW + 2;
  localparam int OW  = cpg_pkg::OUT_W;
  localparam int NST = 6;
  localparam logic signed [SW-1:0] MAXV = SW'({1'b0, {(OW-1){1'b1}}});
  localparam logic signed [SW-1:0] MINV = -MAXV - SW'(1);

  typedef struct packed {
    logic signed [XW-1:0] c;
    logic signed [XW-1:0] s;
  } s0_t;

  typedef struct packed {
    logic signed [PW-1:0] p;
    logic signed [PW-1:0] q;
  } s1_t;

  typedef struct packed {
    logic signed [PAW-1:0] pa;
    logic signed [PAW-1:0] pb;
    logic                  pneg;
    logic                  qneg;
    logic [3:0][63:0]      pt;
    logic [3:0][63:0]      qt;
    logic [3:0][63:0]      pf;
    logic [3:0][63:0]      qf;
  } s2_t;

  typedef struct packed {
    logic signed [PAW-1:0] pa;
    logic signed [PAW-1:0] pb;
    logic signed [VW-1:0]  va;
    logic signed [VW-1:0]  vb;
    logic signed [VW-1:0]  aa;
    logic signed [VW-1:0]  ab;
  } s3_t;

  typedef struct packed {
    logic [2:0][5:0][MW-1:0] m;
  } s4_t;

  typedef struct packed {
    logic [8:0][OW-1:0] r;
    logic               sat;
  } s5_t;

  logic [NST-1:0] v_q;
  logic [NST-1:0] en;
  s0_t s0_d, s0_q;
  s1_t s1_d, s1_q;
  s2_t s2_d, s2_q;
  s3_t s3_d, s3_q;
  s4_t s4_d, s4_q;
  s5_t s5_d, s5_q;

  logic signed [19:0] axu [3];
  logic signed [19:0] axv [3];
  logic signed [MW-1:0] mt [3][6];
  logic signed [SW-1:0] sum [9];
  logic signed [SW-1:0] ctr [3];
  logic [63:0] pm, qm;

  always_comb begin
    en[NST-1] = !v_q[NST-1] || out_if.ready;
    for (int k = NST - 2; k >= 0; k--) en[k] = !v_q[k] || en[k+1];
  end
  assign ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // quadrant fold
  always_comb begin
    case (data_i.quad)
      2'd0:    begin s0_d.c = data_i.x;  s0_d.s = data_i.y;  end
      2'd1:    begin s0_d.c = -data_i.y; s0_d.s = data_i.x;  end
      2'd2:    begin s0_d.c = -data_i.x; s0_d.s = -data_i.y; end
      default: begin s0_d.c = data_i.y;  s0_d.s = -data_i.x; end
    endcase
  end

  always_comb begin
    s1_d.p = $signed({1'b0, radius_i}) * s0_q.c;
    s1_d.q = $signed({1'b0, radius_i}) * s0_q.s;
  end

  function automatic logic signed [PAW-1:0] rnd22(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] t;
    logic signed [PW-1:0] r;
    t = v + (PW'(1) << 21) - PW'(v[PW-1]);
    r = t >>> 22;
    return r[PAW-1:0];
  endfunction

  function automatic logic [3:0][63:0] pprod(input logic [63:0] a, input logic [63:0] b);
    logic [3:0][63:0] pp;
    pp[0] = 64'(a[31:0])  * 64'(b[31:0]);
    pp[1] = 64'(a[31:0])  * 64'(b[63:32]);
    pp[2] = 64'(a[63:32]) * 64'(b[31:0]);
    pp[3] = 64'(a[63:32]) * 64'(b[63:32]);
    return pp;
  endfunction

  always_comb begin
    pm = s1_q.p[PW-1] ? 64'(-s1_q.p) : s1_q.p[63:0];
    qm = s1_q.q[PW-1] ? 64'(-s1_q.q) : s1_q.q[63:0];
    s2_d.pa   = rnd22(s1_q.p);
    s2_d.pb   = rnd22(s1_q.q);
    s2_d.pneg = s1_q.p[PW-1];
    s2_d.qneg = s1_q.q[PW-1];
    s2_d.pt   = pprod(pm, cpg_pkg::TWO_PI_Q60);
    s2_d.qt   = pprod(qm, cpg_pkg::TWO_PI_Q60);
    s2_d.pf   = pprod(pm, cpg_pkg::FOUR_PI_SQ);
    s2_d.qf   = pprod(qm, cpg_pkg::FOUR_PI_SQ);
  end

  // round(a*b / 2^s) with halves up, negated when neg is set
  function automatic logic signed [VW-1:0] wround(input logic [3:0][63:0] pp,
                                                  input int s, input logic neg);
    logic [127:0] f;
    logic [127:0] r;
    f = 128'(pp[0]) + (128'(pp[1]) << 32) + (128'(pp[2]) << 32) + (128'(pp[3]) << 64);
    r = (f + (128'(1) << (s - 1))) >> s;
    return neg ? -$signed(VW'(r)) : $signed(VW'(r));
  endfunction

  always_comb begin
    s3_d.pa = s2_q.pa;
    s3_d.pb = s2_q.pb;
    s3_d.va = wround(s2_q.qt, 82, !s2_q.qneg);
    s3_d.vb = wround(s2_q.pt, 82, s2_q.pneg);
    s3_d.aa = wround(s2_q.pf, 78, !s2_q.pneg);
    s3_d.ab = wround(s2_q.qf, 78, !s2_q.qneg);
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      axu[k]   = axis_u_i[20*k +: 20];
      axv[k]   = axis_v_i[20*k +: 20];
      mt[k][0] = axu[k] * s3_q.pa;
      mt[k][1] = axv[k] * s3_q.pb;
      mt[k][2] = axu[k] * s3_q.va;
      mt[k][3] = axv[k] * s3_q.vb;
      mt[k][4] = axu[k] * s3_q.aa;
      mt[k][5] = axv[k] * s3_q.ab;
      for (int j = 0; j < 6; j++) s4_d.m[k][j] = mt[k][j];
    end
  end

  function automatic logic signed [RW-1:0] rnd18(input logic [MW-1:0] v);
    logic signed [MW-1:0] t;
    logic signed [MW-1:0] r;
    t = $signed(v) + (MW'(1) << 17) - MW'(v[MW-1]);
    r = t >>> 18;
    return r[RW-1:0];
  endfunction

  always_comb begin
    ctr[0]   = SW'(center_x_i);
    ctr[1]   = SW'(center_y_i);
    ctr[2]   = SW'(center_z_i);
    s5_d.sat = 1'b0;
    for (int k = 0; k < 3; k++) begin
      sum[k]   = SW'(rnd18(s4_q.m[k][0])) + SW'(rnd18(s4_q.m[k][1])) + ctr[k];
      sum[3+k] = SW'(rnd18(s4_q.m[k][2])) + SW'(rnd18(s4_q.m[k][3]));
      sum[6+k] = SW'(rnd18(s4_q.m[k][4])) + SW'(rnd18(s4_q.m[k][5]));
    end
    for (int n = 0; n < 9; n++) begin
      if (sum[n] > MAXV) begin
        s5_d.r[n] = MAXV[OW-1:0];
        s5_d.sat  = 1'b1;
      end else if (sum[n] < MINV) begin
        s5_d.r[n] = MINV[OW-1:0];
        s5_d.sat  = 1'b1;
      end else begin
        s5_d.r[n] = sum[n][OW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) s0_q <= s0_d;
    if (en[1]) s1_q <= s1_d;
    if (en[2]) s2_q <= s2_d;
    if (en[3]) s3_q <= s3_d;
    if (en[4]) s4_q <= s4_d;
    if (en[5]) s5_q <= s5_d;
  end

  assign out_if.valid     = v_q[NST-1];
  assign out_if.pos_x     = s5_q.r[0];
  assign out_if.pos_y     = s5_q.r[1];
  assign out_if.pos_z     = s5_q.r[2];
  assign out_if.vel_x     = s5_q.r[3];
  assign out_if.vel_y     = s5_q.r[4];
  assign out_if.vel_z     = s5_q.r[5];
  assign out_if.acc_x     = s5_q.r[6];
  assign out_if.acc_y     = s5_q.r[7];
  assign out_if.acc_z     = s5_q.r[8];
  assign out_if.saturated = s5_q.sat;

endmodule

// ===== src/circle_path_point_generator_top.sv =====
// Circle path point generator: each gamma item (Q8.24, clamped to 0..1 turn) yields one
// result item with position, first and second derivative of a 3-D circle, Q24.24, saturated.
// A new item is taken every cycle while the output is not stalled; the items pass a chain of
// CORDIC cells (one rotation each) followed by six mapping stages (quadrant fold, radius
// multiply, partial products, rounding sum, axis multiply, final sum and clip). Every stage
// loads when it is empty or its successor moves, so a stalled output holds only the items
// already queued. Configuration writes are registered and should be made while idle.
module circle_path_point_generator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [59:0] cfg_data_i,
  cpg_in_if.sink      in_if,
  cpg_out_if.source   out_if
);

  localparam int N   = cpg_pkg::CORDIC_STAGES;
  localparam int GFB = cpg_pkg::GAMMA_FRAC_BITS;

  logic [31:0]        radius_q;
  logic signed [47:0] center_x_q, center_y_q, center_z_q;
  logic [59:0]        axis_u_q, axis_v_q;

  cpg_pkg::cord_t cd [N+1];
  logic           cv [N+1];
  logic           cr [N+1];
  logic [63:0]    phase;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q   <= 32'd65536;
      center_x_q <= '0;
      center_y_q <= '0;
      center_z_q <= '0;
      axis_u_q   <= 60'd262144;
      axis_v_q   <= 60'd274877906944;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cpg_pkg::REG_RADIUS:   radius_q   <= cfg_data_i[31:0];
        cpg_pkg::REG_CENTER_X: center_x_q <= cfg_data_i[47:0];
        cpg_pkg::REG_CENTER_Y: center_y_q <= cfg_data_i[47:0];
        cpg_pkg::REG_CENTER_Z: center_z_q <= cfg_data_i[47:0];
        cpg_pkg::REG_AXIS_U:   axis_u_q   <= cfg_data_i;
        cpg_pkg::REG_AXIS_V:   axis_v_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamp; a negative gamma or one of a full turn or more maps to zero
  always_comb begin
    if (in_if.gamma[31] || in_if.gamma >= $signed(32'(1) << GFB)) phase = '0;
    else phase = 64'(in_if.gamma[30:0]) << (64 - GFB);
    cd[0].quad = phase[63:62];
    cd[0].x    = cpg_pkg::CORDIC_X0;
    cd[0].y    = '0;
    cd[0].z    = {2'b00, phase[61:0]};
  end

  assign cv[0]       = in_if.valid;
  assign in_if.ready = cr[0];

  for (genvar g = 0; g < N; g++) begin : g_cell
    cpg_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (cpg_pkg::SHW'(g)),
      .atan_i  (cpg_pkg::atan_f(g)),
      .valid_i (cv[g]),
      .ready_o (cr[g]),
      .data_i  (cd[g]),
      .valid_o (cv[g+1]),
      .ready_i (cr[g+1]),
      .data_o  (cd[g+1])
    );
  end

  cpg_map u_map (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (cv[N]),
    .ready_o    (cr[N]),
    .data_i     (cd[N]),
    .radius_i   (radius_q),
    .center_x_i (center_x_q),
    .center_y_i (center_y_q),
    .center_z_i (center_z_q),
    .axis_u_i   (axis_u_q),
    .axis_v_i   (axis_v_q),
    .out_if     (out_if)
  );

endmodule

// ===== src/cpg_checker.sv =====
module cpg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [47:0] pos_x_i,
  input logic [47:0] pos_y_i,
  input logic [47:0] pos_z_i,
  input logic [47:0] vel_x_i,
  input logic [47:0] vel_y_i,
  input logic [47:0] vel_z_i,
  input logic [47:0] acc_x_i,
  input logic [47:0] acc_y_i,
  input logic [47:0] acc_z_i,
  input logic        sat_i
);

  localparam logic [47:0] MAXV = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] MINV = 48'h8000_0000_0000;

  // stalled result stays put (checked on pos_x and acc_z)
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(pos_x_i) && $stable(acc_z_i))
    else $error("result changed while stalled");

  // empty output stage means the whole chain can take an item
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output");

  // a draining output lets every stage advance
  a_thru: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_i)
    else $error("input stalled while output drains");

  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && sat_i |->
      pos_x_i == MAXV || pos_x_i == MINV || pos_y_i == MAXV || pos_y_i == MINV ||
      pos_z_i == MAXV || pos_z_i == MINV || vel_x_i == MAXV || vel_x_i == MINV ||
      vel_y_i == MAXV || vel_y_i == MINV || vel_z_i == MAXV || vel_z_i == MINV ||
      acc_x_i == MAXV || acc_x_i == MINV || acc_y_i == MAXV || acc_y_i == MINV ||
      acc_z_i == MAXV || acc_z_i == MINV)
    else $error("saturation flag without clipped component");

endmodule

bind circle_path_point_generator_top cpg_checker u_cpg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .pos_x_i     (out_if.pos_x),
  .pos_y_i     (out_if.pos_y),
  .pos_z_i     (out_if.pos_z),
  .vel_x_i     (out_if.vel_x),
  .vel_y_i     (out_if.vel_y),
  .vel_z_i     (out_if.vel_z),
  .acc_x_i     (out_if.acc_x),
  .acc_y_i     (out_if.acc_y),
  .acc_z_i     (out_if.acc_z),
  .sat_i       (out_if.saturated)
);
